### rtl/delimited_key_extractor_top_assert.svh
// Assertion macros for the delimited key extractor checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef DELIMITED_KEY_EXTRACTOR_TOP_ASSERT_SVH
`define DELIMITED_KEY_EXTRACTOR_TOP_ASSERT_SVH

// Antecedent in this cycle implies consequent in the next; quiet during reset
`define DKE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dke: next-cycle check failed");

// Antecedent implies consequent in the same cycle; quiet during reset
`define DKE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dke: same-cycle check failed");

// Next-cycle check that also holds across reset
`define DKE_ASSERT_ALWAYS_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dke: reset check failed");

`endif

### rtl/dke_pkg.sv
// ----------------------------------------------------------------------------
// dke_pkg
// Shared constants, register codes and helpers of the delimited key extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package dke_pkg;

  localparam int BYTE_W      = 8;
  localparam int SEP_LEN_W   = 4;
  localparam int SEP_SLOTS   = 8;
  localparam int SEP_IDX_W   = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 64;

  localparam logic [BYTE_W-1:0] LINE_END = 8'd10;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEP_LEN   = 1'd0,
    REG_SEP_BYTES = 1'd1
  } cfg_reg_t;

  // Pick separator byte i out of the packed separator word
  function automatic logic [BYTE_W-1:0] sep_byte(input logic [CFG_DATA_W-1:0] sb,
                                                 input logic [SEP_IDX_W-1:0] i);
    logic [BYTE_W-1:0] b;
    b = sb[i*BYTE_W +: BYTE_W];
    return b;
  endfunction

endpackage

`default_nettype wire

### rtl/dke_stream_if.sv
// ----------------------------------------------------------------------------
// dke_in_if / dke_out_if
// Valid/ready byte channels for text input and key output.
// ----------------------------------------------------------------------------
`default_nettype none

interface dke_in_if import dke_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface dke_out_if import dke_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

`default_nettype wire

### rtl/dke_key_ram.sv
// ----------------------------------------------------------------------------
// dke_key_ram
// Key byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dke_key_ram import dke_pkg::*; #(
  parameter int DEPTH = 63,
  parameter int AW    = 6
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [BYTE_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data valid the cycle after re
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/dke_ctrl.sv
// ----------------------------------------------------------------------------
// dke_ctrl
// Separator matcher and key sequencer: appends key bytes to the store one
// write per cycle and plays a finished key back through the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dke_ctrl import dke_pkg::*; #(
  parameter int MAX_SEP_LEN = 8,
  parameter int MAX_KEY_LEN = 63,
  parameter int AW          = 6,
  parameter int LW          = 6,
  parameter int MW          = 3
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // text input
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [BYTE_W-1:0]     in_byte,
  // key output
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [BYTE_W-1:0]     out_byte,
  // key store
  output logic                       ram_we,
  output logic      [AW-1:0]         ram_waddr,
  output logic      [BYTE_W-1:0]     ram_wdata,
  output logic                       ram_re,
  output logic      [AW-1:0]         ram_raddr,
  input  wire logic [BYTE_W-1:0]     ram_rdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_EMIT_RD,
    S_EMIT_WAIT,
    S_NEWLINE
  } state_t;

  state_t                state;
  logic [SEP_LEN_W-1:0]  sep_len;
  logic [CFG_DATA_W-1:0] sep_bytes;
  logic                  in_key;
  logic [MW-1:0]         match_index;
  logic [LW-1:0]         key_length;
  logic [MW-1:0]         app_ptr;
  logic [LW-1:0]         rd_ptr;
  logic [BYTE_W-1:0]     held_byte;

  logic [SEP_LEN_W-1:0]  sep_n;
  logic [MW-1:0]         mi_eff;
  logic [SEP_LEN_W-1:0]  mi_inc;
  logic                  sep_hit;
  logic                  sep_done;
  logic                  out_free;
  logic                  out_load;
  logic                  key_room;
  logic [LW-1:0]         rd_ptr_inc;

  // Effective separator length, clamped to 1..MAX_SEP_LEN
  always_comb begin
    if (sep_len == '0) begin
      sep_n = SEP_LEN_W'(1);
    end else if (sep_len > SEP_LEN_W'(MAX_SEP_LEN)) begin
      sep_n = SEP_LEN_W'(MAX_SEP_LEN);
    end else begin
      sep_n = sep_len;
    end
  end

  // Match compare against the current separator position
  assign mi_eff     = (SEP_LEN_W'(match_index) >= sep_n) ? '0 : match_index;
  assign mi_inc     = SEP_LEN_W'(mi_eff) + SEP_LEN_W'(1);
  assign sep_hit    = (in_byte == sep_byte(sep_bytes, SEP_IDX_W'(mi_eff)));
  assign sep_done   = (mi_inc == sep_n);
  assign out_free   = !out_valid || out_ready;
  assign out_load   = out_free && ((state == S_EMIT_WAIT) || (state == S_NEWLINE));
  assign key_room   = (key_length < LW'(MAX_KEY_LEN));
  assign rd_ptr_inc = rd_ptr + LW'(1);
  assign in_ready   = (state == S_IDLE);

  // Store write: matched separator prefix first, then the breaking byte
  assign ram_we    = (state == S_APPEND) && key_room;
  assign ram_waddr = AW'(key_length);
  assign ram_wdata = (app_ptr == match_index) ? held_byte
                                              : sep_byte(sep_bytes, SEP_IDX_W'(app_ptr));

  // Store read during playback
  assign ram_re    = (state == S_EMIT_RD);
  assign ram_raddr = AW'(rd_ptr);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sep_len   <= SEP_LEN_W'(1);
      sep_bytes <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SEP_LEN:   sep_len   <= cfg_data[SEP_LEN_W-1:0];
        REG_SEP_BYTES: sep_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      in_key      <= 1'b0;
      match_index <= '0;
      key_length  <= '0;
      app_ptr     <= '0;
      rd_ptr      <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (sep_hit) begin
              if (sep_done) begin
                match_index <= '0;
                if (!in_key) begin
                  in_key     <= 1'b1;
                  key_length <= '0;
                end else begin
                  in_key <= 1'b0;
                  rd_ptr <= '0;
                  state  <= (key_length == '0) ? S_NEWLINE : S_EMIT_RD;
                end
              end else begin
                match_index <= MW'(mi_inc);
              end
            end else if (!in_key) begin
              match_index <= '0;
            end else begin
              // broken closing match: append prefix and this byte
              held_byte   <= in_byte;
              match_index <= mi_eff;
              app_ptr     <= '0;
              state       <= S_APPEND;
            end
          end
        end
        S_APPEND: begin
          if (key_room) begin
            key_length <= key_length + LW'(1);
          end
          if (app_ptr == match_index) begin
            match_index <= '0;
            state       <= S_IDLE;
          end else begin
            app_ptr <= app_ptr + MW'(1);
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_WAIT;
        end
        S_EMIT_WAIT: begin
          if (out_free) begin
            out_byte  <= ram_rdata;
            rd_ptr    <= rd_ptr_inc;
            state     <= (rd_ptr_inc == key_length) ? S_NEWLINE : S_EMIT_RD;
          end
        end
        S_NEWLINE: begin
          if (out_free) begin
            out_byte   <= LINE_END;
            key_length <= '0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/delimited_key_extractor_top.sv
// ----------------------------------------------------------------------------
// delimited_key_extractor_top
// Finds keys enclosed between two copies of a configured separator in a
// byte stream and emits each key followed by a newline.
//
//   channel   dir  handshake     payload
//   text_in   in   valid/ready   in_byte  (8 bits)
//   key_out   out  valid/ready   out_byte (8 bits)
//   cfg_*     in   cfg_we only   cfg_idx, cfg_data (64 bits)
//
// A byte that breaks a closing match after k matched bytes writes up to k + 1
// bytes into the key store, which has one write port, one byte per cycle; no
// text is taken meanwhile. Closing a key plays each byte back as a registered
// store read and a move into the output register, then sends the line end.
// Synchronous active-high reset; no clearing pass. A stalled key_out holds the
// output register and the playback sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module delimited_key_extractor_top import dke_pkg::*; #(
  parameter int MAX_SEP_LEN = 8,
  parameter int MAX_KEY_LEN = 63
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  dke_in_if.sink                     text_in,
  dke_out_if.source                  key_out
);

  localparam int AW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam int LW = $clog2(MAX_KEY_LEN + 1);
  localparam int MW = (MAX_SEP_LEN > 1) ? $clog2(MAX_SEP_LEN) : 1;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  // Matcher and sequencer
  dke_ctrl #(
    .MAX_SEP_LEN (MAX_SEP_LEN),
    .MAX_KEY_LEN (MAX_KEY_LEN),
    .AW          (AW),
    .LW          (LW),
    .MW          (MW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .in_valid  (text_in.valid),
    .in_ready  (text_in.ready),
    .in_byte   (text_in.in_byte),
    .out_valid (key_out.valid),
    .out_ready (key_out.ready),
    .out_byte  (key_out.out_byte),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Key store
  dke_key_ram #(
    .DEPTH (MAX_KEY_LEN),
    .AW    (AW)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

### rtl/dke_checker.sv
// ----------------------------------------------------------------------------
// dke_checker
// Port-level checks of the delimited key extractor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "delimited_key_extractor_top_assert.svh"

module dke_checker import dke_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [BYTE_W-1:0] out_byte
);

  // A stalled output item holds
  `DKE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte))

  // Nothing is offered right after reset
  `DKE_ASSERT_ALWAYS_NEXT(a_rst_quiet, rst, !out_valid)

  // A key byte taken means playback is still running, so no text is taken with it
  `DKE_ASSERT_SAME(a_play_blocks, out_valid && out_ready && out_byte != LINE_END, !in_ready)

  // While text is taken, only a line end can still wait at the output
  `DKE_ASSERT_SAME(a_idle_tail, in_valid && in_ready && out_valid, out_byte == LINE_END)

endmodule

bind delimited_key_extractor_top dke_checker u_dke_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (text_in.valid),
  .in_ready  (text_in.ready),
  .out_valid (key_out.valid),
  .out_ready (key_out.ready),
  .out_byte  (key_out.out_byte)
);

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the delimited key extractor. Text bytes go in on the
// text_in channel, and a scoreboard works out the key bytes and line ends that
// each accepted item should release. Every byte taken from key_out is checked
// in order. The run walks through several separator settings and idling mixes.
// ----------------------------------------------------------------------------

module tb_top;
  import dke_pkg::*;

  localparam int MAX_SEP  = 8;
  localparam int MAX_KEY  = 63;
  localparam int SETTLE   = 24;     // covers the longest broken closing match
  localparam int HOLD_LEN = 300;    // long receiver hold-off, in cycles

  // Scoreboard: tracks separator matching and the key store, queues the
  // bytes each closed key should emit and checks them as they arrive
  class key_line_tracker;
    logic [SEP_LEN_W-1:0]  sep_len_reg;
    logic [CFG_DATA_W-1:0] sep_word;
    bit                    in_key_body;
    int unsigned           match_pos;
    logic [BYTE_W-1:0]     key_buf[MAX_KEY];
    int unsigned           key_len;
    bit                    key_trunc;
    logic [BYTE_W-1:0]     expected_key_bytes[$];
    int unsigned           mismatches;
    int unsigned           keys_closed;
    int unsigned           truncated_keys;
    int unsigned           bytes_checked;

    function new();
      sep_len_reg = 4'd1;
      sep_word    = '0;
      in_key_body = 1'b0;
      match_pos   = 0;
      key_len     = 0;
      key_trunc   = 1'b0;
      foreach (key_buf[i]) key_buf[i] = '0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_SEP_LEN:   sep_len_reg = val[SEP_LEN_W-1:0];
        REG_SEP_BYTES: sep_word = val;
        default: ;
      endcase
    endfunction

    // Zero acts as one, anything above the slot count is clamped
    function int unsigned eff_len();
      int unsigned n;
      n = sep_len_reg;
      if (n == 0) n = 1;
      if (n > MAX_SEP) n = MAX_SEP;
      return n;
    endfunction

    function logic [BYTE_W-1:0] sep_char(int unsigned i);
      return sep_word[(i & 7) * BYTE_W +: BYTE_W];
    endfunction

    function void append_key_byte(logic [BYTE_W-1:0] b);
      if (key_len < MAX_KEY) begin
        key_buf[key_len] = b;
        key_len++;
      end else begin
        key_trunc = 1'b1;
      end
    endfunction

    // Accepted text item
    function void note_text_byte(logic [BYTE_W-1:0] b);
      int unsigned n;
      n = eff_len();
      if (match_pos >= n) match_pos = 0;
      // hunting: a break drops the byte and restarts at the first slot
      if (!in_key_body) begin
        if (b == sep_char(match_pos)) begin
          match_pos++;
          if (match_pos == n) begin
            in_key_body = 1'b1;
            match_pos   = 0;
            key_len     = 0;
            key_trunc   = 1'b0;
          end
        end else begin
          match_pos = 0;
        end
        return;
      end
      // inside a key: full closing match releases the key and a line end
      if (b == sep_char(match_pos)) begin
        match_pos++;
        if (match_pos == n) begin
          for (int i = 0; i < key_len; i++) expected_key_bytes.push_back(key_buf[i]);
          expected_key_bytes.push_back(LINE_END);
          keys_closed++;
          if (key_trunc) truncated_keys++;
          in_key_body = 1'b0;
          match_pos   = 0;
          key_len     = 0;
        end
        return;
      end
      // broken closing match: matched prefix and breaking byte join the key
      for (int i = 0; i < match_pos; i++) append_key_byte(sep_char(i));
      append_key_byte(b);
      match_pos = 0;
    endfunction

    // Accepted key_out item
    function void check_key_byte(logic [BYTE_W-1:0] got);
      logic [BYTE_W-1:0] want;
      if (expected_key_bytes.size() == 0) begin
        mismatches++;
        $error("out_byte unexpected: expected none, actual 0x%02h", got);
        return;
      end
      want = expected_key_bytes.pop_front();
      bytes_checked++;
      if (got !== want) begin
        mismatches++;
        $error("out_byte mismatch: expected 0x%02h, actual 0x%02h", want, got);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  dke_in_if  text_in();
  dke_out_if key_out();

  key_line_tracker tracker = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_sent    = 0;
  int unsigned sep_loads     = 0;
  bit          hold_request  = 1'b0;

  delimited_key_extractor_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .text_in  (text_in),
    .key_out  (key_out)
  );

  always #2 clk = ~clk;

  // Receiver: random ready, with a long hold-off on request
  initial begin : key_receiver
    int hold_left;
    hold_left     = 0;
    key_out.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left    = HOLD_LEN;
        hold_request = 1'b0;
      end
      if (rst || hold_left > 0) begin
        key_out.ready <= 1'b0;
        if (hold_left > 0) hold_left--;
      end else begin
        key_out.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Output monitor
  always @(posedge clk) begin
    if (!rst && key_out.valid === 1'b1 && key_out.ready === 1'b1)
      tracker.check_key_byte(key_out.out_byte);
  end

  // Offer one text byte, holding valid until it is taken
  task automatic send_text_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      text_in.valid <= 1'b0;
      @(posedge clk);
    end
    text_in.valid   <= 1'b1;
    text_in.in_byte <= b;
    do @(posedge clk); while (text_in.ready !== 1'b1);
    tracker.note_text_byte(b);
    items_sent++;
  endtask

  task automatic send_separator();
    for (int i = 0; i < tracker.eff_len(); i++) send_text_byte(tracker.sep_char(i));
  endtask

  // One enclosed key; mixed content sprinkles separator bytes and
  // broken separator prefixes among random bytes
  task automatic send_key(input int unsigned len, input bit mixed);
    int unsigned n;
    int unsigned r;
    int unsigned k;
    n = tracker.eff_len();
    send_separator();
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (mixed && r < 20) begin
        send_text_byte(tracker.sep_char($urandom_range(0, n - 1)));
      end else if (mixed && r < 30 && n > 1) begin
        k = $urandom_range(1, n - 1);
        for (int j = 0; j < k; j++) send_text_byte(tracker.sep_char(j));
        send_text_byte(BYTE_W'($urandom_range(0, 255)));
      end else begin
        send_text_byte(BYTE_W'($urandom_range(0, 255)));
      end
    end
    send_separator();
  endtask

  // Stray bytes or a broken opening separator
  task automatic send_noise();
    int unsigned n;
    int unsigned k;
    n = tracker.eff_len();
    if ($urandom_range(0, 1) == 0 || n == 1) begin
      repeat ($urandom_range(1, 4)) send_text_byte(BYTE_W'($urandom_range(0, 255)));
    end else begin
      k = $urandom_range(1, n - 1);
      for (int j = 0; j < k; j++) send_text_byte(tracker.sep_char(j));
      send_text_byte(BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  // Mostly well-formed keys of mostly short length, some noise
  task automatic run_random_text(input int unsigned count);
    int unsigned goal;
    int unsigned r;
    goal = items_sent + count;
    while (items_sent < goal) begin
      r = $urandom_range(0, 99);
      if (r < 55)      send_key($urandom_range(0, 8), 1'b1);
      else if (r < 75) send_key($urandom_range(9, 24), 1'b1);
      else if (r < 80) send_key($urandom_range(25, 40), 1'b1);
      else             send_noise();
    end
  endtask

  // Stop offering, wait for every expected key byte, then let the block settle
  task automatic wait_keys_drained();
    text_in.valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_key_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Both separator registers, written back to back while idle
  task automatic load_separator(input logic [SEP_LEN_W-1:0] len,
                                input logic [CFG_DATA_W-1:0] word);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_SEP_LEN;
    cfg_data <= CFG_DATA_W'(len);
    @(posedge clk);
    tracker.write_reg(REG_SEP_LEN, CFG_DATA_W'(len));
    cfg_idx  <= REG_SEP_BYTES;
    cfg_data <= word;
    @(posedge clk);
    tracker.write_reg(REG_SEP_BYTES, word);
    cfg_we   <= 1'b0;
    @(posedge clk);
    sep_loads++;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Main sequence
  initial begin : stimulus
    logic [BYTE_W-1:0] rep;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_idx         = REG_SEP_LEN;
    cfg_data        = '0;
    text_in.valid   = 1'b0;
    text_in.in_byte = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sender idles more rarely than the receiver
    set_idling(23, 49);

    // reset separator is a single zero byte: one-byte key, then empty key
    send_text_byte(8'h00);
    send_text_byte(8'hFF);
    send_text_byte(8'h00);
    send_text_byte(8'h00);
    send_text_byte(8'h00);
    wait_keys_drained();

    // separator "%%!": broken openings, broken closing on the first
    // separator byte, then an empty key
    load_separator(4'd3, 64'h0000_0000_0021_2525);
    send_text_byte(8'h25);
    send_text_byte(8'h78);
    send_text_byte(8'h25);
    send_text_byte(8'h25);
    send_text_byte(8'h78);
    send_separator();
    send_text_byte(8'h6B);
    send_text_byte(8'h25);
    send_text_byte(8'h25);
    send_text_byte(8'h25);
    send_separator();
    send_separator();
    send_separator();
    wait_keys_drained();

    load_separator(4'd0, {$urandom, $urandom});
    run_random_text(6);
    wait_keys_drained();
    load_separator(4'd8, {$urandom, $urandom});
    hold_request = 1'b1;
    send_key(20, 1'b1);
    send_key(6, 1'b0);
    run_random_text(6);
    wait_keys_drained();

    // receiver idles more rarely than the sender
    set_idling(49, 23);
    load_separator(4'd15, '1);
    run_random_text(6);
    wait_keys_drained();
    load_separator(4'($urandom_range(2, 7)), {$urandom, $urandom});
    run_random_text(3);
    wait_keys_drained();
    run_random_text(3);
    wait_keys_drained();

    // no idling: repeated-byte separator, an overlong key, single zero byte
    set_idling(0, 0);
    rep = BYTE_W'($urandom_range(0, 255));
    load_separator(4'd4, {8{rep}});
    send_key(68, 1'b0);
    run_random_text(6);
    wait_keys_drained();
    load_separator(4'd1, '0);
    run_random_text(6);

    // a key left open at the end of the text is never emitted
    send_separator();
    repeat (3) send_text_byte(BYTE_W'($urandom_range(0, 255)));
    wait_keys_drained();

    $display("Sent %0d text items over %0d separator settings",
             items_sent, sep_loads);
    $display("Checked %0d key bytes in %0d keys (%0d truncated)",
             tracker.bytes_checked, tracker.keys_closed, tracker.truncated_keys);
    if (tracker.mismatches == 0 && tracker.expected_key_bytes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #2_000_000;
    $error("timeout with %0d key bytes still expected",
           tracker.expected_key_bytes.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
